[hdl/bprq_pkg.sv]
// ----------------------------------------------------------------------------
// bprq_pkg - shared definitions of the bitmap priority ready queue
// Group geometry of the ready bitmap, parameter defaults and sequencer states.
// ----------------------------------------------------------------------------
package bprq_pkg;

   // levels per bitmap word and the shift that picks the word
   localparam int GROUP_BITS  = 32;
   localparam int GROUP_SHIFT = 5;
   // width of a group number as it sits in the upper bits of a level
   localparam int GROUP_NUM_W = 3;

   localparam int TASK_ID_W   = 6;
   localparam int LEVEL_W     = 8;

   localparam int DEF_NUM_TASKS  = 64;
   localparam int DEF_NUM_LEVELS = 256;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_ENQ     = 7'b0000010,
      ST_ENQ_WR  = 7'b0000100,
      ST_DEQ_GRP = 7'b0001000,
      ST_DEQ_LVL = 7'b0010000,
      ST_DEQ_CMP = 7'b0100000,
      ST_DEQ_WR  = 7'b1000000
   } state_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

endpackage

[hdl/bitmap_priority_ready_queue.sv]
// ----------------------------------------------------------------------------
// bitmap_priority_ready_queue - hardware run queue with two-level ready bitmap
// One FIFO of task ids per priority level, linked through a next-task memory,
// with a word-per-group bitmap and a group summary for the dequeue search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the operation is finished, and its single result is shown for exactly
// one cycle on rsp_valid, in the cycle in which busy falls. The receiver
// cannot stall the result, so capture it whenever rsp_valid is high. An
// enqueue into an empty level, an out-of-range task id and a dequeue from an
// empty queue end in their first state; an enqueue behind existing tasks
// first reads the tail from the tail memory; a dequeue that finds a task
// runs the group search, the level search and a head-tail compare, and one
// that leaves tasks behind then writes the new head from the link memory.
// The sequencer shares one 32-bit priority encoder between the group search
// and the level search, and the head, tail and link memories have registered
// reads. A new request may be given in the strobe cycle. The list memories
// need no clearing after reset: a level bit marks its head and tail as
// written.
// ----------------------------------------------------------------------------
module bitmap_priority_ready_queue #(
   parameter int NUM_TASKS  = bprq_pkg::DEF_NUM_TASKS,
   parameter int NUM_LEVELS = bprq_pkg::DEF_NUM_LEVELS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [bprq_pkg::TASK_ID_W-1:0]   req_task_id,
   input  logic [bprq_pkg::LEVEL_W-1:0]     req_priority_req,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [bprq_pkg::TASK_ID_W-1:0]   rsp_out_task_id
);

   localparam int TW = $clog2(NUM_TASKS);
   localparam int LW = $clog2(NUM_LEVELS);
   localparam int NUM_GROUPS = (NUM_LEVELS + bprq_pkg::GROUP_BITS - 1)
                               >> bprq_pkg::GROUP_SHIFT;
   localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam logic [bprq_pkg::LEVEL_W-1:0] TOP_LEVEL =
      bprq_pkg::LEVEL_W'(NUM_LEVELS - 1);

   // sequencer and captured request
   bprq_pkg::state_type state_ff, state_in;
   logic [bprq_pkg::TASK_ID_W-1:0]   task_ff, task_in;
   logic [bprq_pkg::LEVEL_W-1:0]     lvl_ff, lvl_in;
   logic [bprq_pkg::GROUP_NUM_W-1:0] grp_ff, grp_in;
   logic [bprq_pkg::LEVEL_W-1:0]     sel_ff, sel_in;

   // ready bitmaps
   logic [bprq_pkg::GROUP_BITS-1:0]  level_bitmap_ff [NUM_GROUPS];
   logic [NUM_GROUPS-1:0]            group_bitmap_ff;

   // list memories and their registered read data
   logic [bprq_pkg::TASK_ID_W-1:0]   head_mem [NUM_LEVELS];
   logic [bprq_pkg::TASK_ID_W-1:0]   tail_mem [NUM_LEVELS];
   logic [bprq_pkg::TASK_ID_W-1:0]   link_mem [NUM_TASKS];
   logic [bprq_pkg::TASK_ID_W-1:0]   head_rd_ff, tail_rd_ff, link_rd_ff;

   // result registers
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [bprq_pkg::TASK_ID_W-1:0]   rsp_task_ff, rsp_task_in;

   // shared encoder
   logic [bprq_pkg::GROUP_BITS-1:0]  enc_word;
   logic [bprq_pkg::GROUP_SHIFT-1:0] enc_idx;

   // control decoded from the state
   logic                             accept;
   logic                             task_ok;
   logic                             lvl_busy;
   logic [GW-1:0]                    lvl_grp;
   logic [bprq_pkg::GROUP_SHIFT-1:0] lvl_bit;
   logic [bprq_pkg::LEVEL_W-1:0]     sel_now;
   logic [bprq_pkg::GROUP_BITS-1:0]  sel_cleared;
   logic [LW-1:0]                    list_rd_addr;
   logic                             head_we, tail_we, link_we;
   logic [LW-1:0]                    head_wa;
   logic [bprq_pkg::TASK_ID_W-1:0]   head_wd;
   logic                             mark, unmark;

   assign accept  = start && (state_ff == bprq_pkg::ST_IDLE);
   assign busy    = (state_ff != bprq_pkg::ST_IDLE);
   assign task_ok = (32'(task_ff) < NUM_TASKS);
   assign lvl_grp = GW'(lvl_ff[bprq_pkg::LEVEL_W-1:bprq_pkg::GROUP_SHIFT]);
   assign lvl_bit = lvl_ff[bprq_pkg::GROUP_SHIFT-1:0];
   assign lvl_busy = level_bitmap_ff[lvl_grp][lvl_bit];

   // group search first, then the level search inside the chosen word
   assign enc_word = (state_ff == bprq_pkg::ST_DEQ_GRP)
                   ? bprq_pkg::GROUP_BITS'(group_bitmap_ff)
                   : level_bitmap_ff[GW'(grp_ff)];

   bprq_prio_enc u_enc (
      .word_in (enc_word),
      .top_idx (enc_idx)
   );

   assign sel_now = {grp_ff, enc_idx};
   assign sel_cleared = level_bitmap_ff[GW'(sel_ff[bprq_pkg::LEVEL_W-1:bprq_pkg::GROUP_SHIFT])]
                      & ~(bprq_pkg::GROUP_BITS'(1) << sel_ff[bprq_pkg::GROUP_SHIFT-1:0]);
   assign list_rd_addr = (state_ff == bprq_pkg::ST_DEQ_LVL) ? LW'(sel_now) : LW'(lvl_ff);

   always_comb begin
      state_in     = state_ff;
      task_in      = task_ff;
      lvl_in       = lvl_ff;
      grp_in       = grp_ff;
      sel_in       = sel_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_task_in  = '0;
      head_we      = 1'b0;
      tail_we      = 1'b0;
      link_we      = 1'b0;
      head_wa      = LW'(lvl_ff);
      head_wd      = task_ff;
      mark         = 1'b0;
      unmark       = 1'b0;
      unique case (state_ff)
         bprq_pkg::ST_IDLE: begin
            if (accept) begin
               task_in = req_task_id;
               // saturate levels beyond the top one
               lvl_in  = (32'(req_priority_req) >= NUM_LEVELS) ? TOP_LEVEL
                                                               : req_priority_req;
               state_in = (req_operation == bprq_pkg::OP_DEQUEUE)
                        ? bprq_pkg::ST_DEQ_GRP : bprq_pkg::ST_ENQ;
            end
         end
         bprq_pkg::ST_ENQ: begin
            if (!task_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = bprq_pkg::ST_IDLE;
            end else if (!lvl_busy) begin
               // empty level: task becomes head and tail
               head_we      = 1'b1;
               tail_we      = 1'b1;
               mark         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bprq_pkg::ST_IDLE;
            end else begin
               state_in = bprq_pkg::ST_ENQ_WR;
            end
         end
         bprq_pkg::ST_ENQ_WR: begin
            // append behind the old tail
            link_we      = 1'b1;
            tail_we      = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = bprq_pkg::ST_IDLE;
         end
         bprq_pkg::ST_DEQ_GRP: begin
            if (group_bitmap_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = bprq_pkg::ST_IDLE;
            end else begin
               grp_in   = bprq_pkg::GROUP_NUM_W'(enc_idx);
               state_in = bprq_pkg::ST_DEQ_LVL;
            end
         end
         bprq_pkg::ST_DEQ_LVL: begin
            sel_in   = sel_now;
            state_in = bprq_pkg::ST_DEQ_CMP;
         end
         bprq_pkg::ST_DEQ_CMP: begin
            if (head_rd_ff == tail_rd_ff) begin
               // last task of the level
               unmark       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_task_in  = head_rd_ff;
               state_in     = bprq_pkg::ST_IDLE;
            end else begin
               state_in = bprq_pkg::ST_DEQ_WR;
            end
         end
         bprq_pkg::ST_DEQ_WR: begin
            head_we      = 1'b1;
            head_wa      = LW'(sel_ff);
            head_wd      = link_rd_ff;
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            rsp_task_in  = head_rd_ff;
            state_in     = bprq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bprq_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bprq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      task_ff      <= task_in;
      lvl_ff       <= lvl_in;
      grp_ff       <= grp_in;
      sel_ff       <= sel_in;
      rsp_found_ff <= rsp_found_in;
      rsp_task_ff  <= rsp_task_in;
   end

   // ready bitmaps
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            level_bitmap_ff[g] <= '0;
         end
         group_bitmap_ff <= '0;
      end else if (mark) begin
         level_bitmap_ff[lvl_grp][lvl_bit] <= 1'b1;
         group_bitmap_ff[lvl_grp]          <= 1'b1;
      end else if (unmark) begin
         level_bitmap_ff[GW'(sel_ff[bprq_pkg::LEVEL_W-1:bprq_pkg::GROUP_SHIFT])] <= sel_cleared;
         if (sel_cleared == '0) begin
            group_bitmap_ff[GW'(sel_ff[bprq_pkg::LEVEL_W-1:bprq_pkg::GROUP_SHIFT])] <= 1'b0;
         end
      end
   end

   // list memories: one write port each, registered reads
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (tail_we) begin
         tail_mem[LW'(lvl_ff)] <= task_ff;
      end
      if (link_we) begin
         link_mem[TW'(tail_rd_ff)] <= task_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bprq_pkg::ST_DEQ_LVL) begin
         head_rd_ff <= head_mem[list_rd_addr];
      end
      if ((state_ff == bprq_pkg::ST_DEQ_LVL) || (state_ff == bprq_pkg::ST_ENQ)) begin
         tail_rd_ff <= tail_mem[list_rd_addr];
      end
      if (state_ff == bprq_pkg::ST_DEQ_CMP) begin
         link_rd_ff <= link_mem[TW'(head_rd_ff)];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_out_task_id = rsp_task_ff;

endmodule

[hdl/bprq_prio_enc.sv]
// ----------------------------------------------------------------------------
// bprq_prio_enc - highest-set-bit encoder of one bitmap word
// Shared by the group search and the level search; zero input gives zero.
// ----------------------------------------------------------------------------
module bprq_prio_enc (
   input  logic [bprq_pkg::GROUP_BITS-1:0]  word_in,
   output logic [bprq_pkg::GROUP_SHIFT-1:0] top_idx
);

   always_comb begin
      top_idx = '0;
      for (int i = 0; i < bprq_pkg::GROUP_BITS; i++) begin
         if (word_in[i]) begin
            top_idx = bprq_pkg::GROUP_SHIFT'(i);
         end
      end
   end

endmodule

[tb/sv/bprq_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// bprq_scoreboard_pkg - expected-result tracking for the ready queue bench
// Mirrors the per-level task lists and the two-level ready bitmap, works out
// what each accepted request must return and compares it with the block.
// ----------------------------------------------------------------------------
package bprq_scoreboard_pkg;

   localparam int TASK_ID_W      = bprq_pkg::TASK_ID_W;
   localparam int LEVEL_W        = bprq_pkg::LEVEL_W;
   localparam int GROUP_BITS     = bprq_pkg::GROUP_BITS;
   localparam int GROUP_SHIFT    = bprq_pkg::GROUP_SHIFT;
   localparam int DEF_NUM_TASKS  = bprq_pkg::DEF_NUM_TASKS;
   localparam int DEF_NUM_LEVELS = bprq_pkg::DEF_NUM_LEVELS;
   localparam int NUM_GROUPS     = DEF_NUM_LEVELS / GROUP_BITS;

   typedef struct packed {
      logic                 found;
      logic [TASK_ID_W-1:0] task_id;
   } dequeue_result_type;

   class ready_queue_scoreboard_type;
      logic [TASK_ID_W-1:0]     head_of      [DEF_NUM_LEVELS];
      logic [TASK_ID_W-1:0]     tail_of      [DEF_NUM_LEVELS];
      logic [TASK_ID_W-1:0]     next_of      [DEF_NUM_TASKS];
      logic [GROUP_BITS-1:0]    ready_word   [NUM_GROUPS];
      logic [NUM_GROUPS-1:0]    ready_groups;
      logic [DEF_NUM_TASKS-1:0] link_set;
      int unsigned              queued_cnt   [DEF_NUM_TASKS];
      dequeue_result_type       awaited      [$];
      int unsigned errors, enqueues, dequeues, hits, misses, repeats;

      function new();
         foreach (head_of[i]) begin
            head_of[i] = '0;
            tail_of[i] = '0;
         end
         foreach (next_of[i]) begin
            next_of[i]    = '0;
            queued_cnt[i] = 0;
         end
         foreach (ready_word[i]) ready_word[i] = '0;
         ready_groups = '0;
         link_set     = '0;
         errors = 0; enqueues = 0; dequeues = 0; hits = 0; misses = 0; repeats = 0;
      endfunction

      function automatic int top_bit(logic [GROUP_BITS-1:0] w);
         for (int b = GROUP_BITS - 1; b > 0; b--) begin
            if (w[b]) return b;
         end
         return 0;
      endfunction

      function automatic bit links_complete();
         return &link_set;
      endfunction

      function automatic bit is_queued(logic [TASK_ID_W-1:0] tid);
         return queued_cnt[tid] != 0;
      endfunction

      function automatic int outstanding();
         return awaited.size();
      endfunction

      task automatic report(string what, int unsigned want, int unsigned got);
         $display("ERROR at %0t: %s: expected %0d, got %0d", $realtime, what, want, got);
         errors++;
      endtask

      // update the mirrored lists for one accepted request and queue its result
      task automatic note_request(bprq_pkg::op_type op, logic [TASK_ID_W-1:0] tid,
                                  logic [LEVEL_W-1:0] prio);
         int unsigned     lvl, grp, sel;
         logic [TASK_ID_W-1:0] hd;
         dequeue_result_type res;
         res = '0;
         if (op == bprq_pkg::OP_ENQUEUE) begin
            lvl = (prio >= DEF_NUM_LEVELS) ? DEF_NUM_LEVELS - 1 : prio;
            enqueues++;
            if (queued_cnt[tid] != 0) repeats++;
            queued_cnt[tid]++;
            grp = lvl >> GROUP_SHIFT;
            if (!ready_word[grp][lvl % GROUP_BITS]) begin
               head_of[lvl] = tid;
               tail_of[lvl] = tid;
               ready_word[grp][lvl % GROUP_BITS] = 1'b1;
               ready_groups[grp] = 1'b1;
            end else begin
               next_of[tail_of[lvl]]  = tid;
               link_set[tail_of[lvl]] = 1'b1;
               tail_of[lvl] = tid;
            end
         end else begin
            dequeues++;
            if (ready_groups == '0) begin
               misses++;
            end else begin
               grp = top_bit(GROUP_BITS'(ready_groups));
               sel = (grp << GROUP_SHIFT) | top_bit(ready_word[grp]);
               hd  = head_of[sel];
               if (hd == tail_of[sel]) begin
                  ready_word[grp][sel % GROUP_BITS] = 1'b0;
                  if (ready_word[grp] == '0) ready_groups[grp] = 1'b0;
               end else begin
                  head_of[sel] = next_of[hd];
               end
               if (queued_cnt[hd] != 0) queued_cnt[hd]--;
               hits++;
               res.found   = 1'b1;
               res.task_id = hd;
            end
         end
         awaited.push_back(res);
      endtask

      task automatic check_result(logic found, logic [TASK_ID_W-1:0] tid);
         dequeue_result_type want;
         if (awaited.size() == 0) begin
            report("result strobe with no request outstanding", 0, 1);
         end else begin
            want = awaited.pop_front();
            if (found !== want.found) report("found flag", want.found, found);
            if (tid !== want.task_id) report("task id", want.task_id, tid);
         end
      endtask

      task automatic check_drained();
         if (awaited.size() != 0)
            report("results still outstanding at the end", 0, awaited.size());
      endtask
   endclass

endpackage

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - run queue bench for bitmap_priority_ready_queue
// Drives enqueue and dequeue commands through the start/busy handshake, with
// a short directed opening and then phases of random traffic, and checks every
// result strobe against a mirrored copy of the lists and ready bitmaps.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_ID_W     = bprq_pkg::TASK_ID_W;
   localparam int LEVEL_W       = bprq_pkg::LEVEL_W;
   localparam int DEF_NUM_TASKS = bprq_pkg::DEF_NUM_TASKS;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 busy;
   logic                 req_operation    = 1'b0;
   logic [TASK_ID_W-1:0] req_task_id      = '0;
   logic [LEVEL_W-1:0]   req_priority_req = '0;
   logic                 rsp_valid;
   logic                 rsp_found;
   logic [TASK_ID_W-1:0] rsp_out_task_id;

   bprq_scoreboard_pkg::ready_queue_scoreboard_type board = new();
   int unsigned          sent = 0;

   bitmap_priority_ready_queue dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_out_task_id  (rsp_out_task_id)
   );

   always #1 clock = ~clock;

   // The receiver cannot stall: take every strobe at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_found, rsp_out_task_id);
   end

   // Present one command and hold it until the edge that transfers it, i.e.
   // the first edge with busy low. Start is left high so that a following
   // command can go out back to back in the strobe cycle.
   task automatic transfer_request(bprq_pkg::op_type op, logic [TASK_ID_W-1:0] tid,
                                   logic [LEVEL_W-1:0] prio);
      start            <= 1'b1;
      req_operation    <= op;
      req_task_id      <= tid;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
      board.note_request(op, tid, prio);
      sent++;
   endtask

   // Drop start for a few cycles so that gaps fall at random points of the
   // sequencer's work.
   task automatic hold_off(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and hold until every outstanding result has been seen. Every
   // command returns a result, so nothing is left in flight after that.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // One phase of random traffic. Half of the levels come from a small pool
   // so that lists grow long and appends, FIFO order and end-of-list pops are
   // exercised; the rest spread over the whole level range.
   task automatic run_phase(int unsigned items, int unsigned enq_pct, bit idling);
      logic [LEVEL_W-1:0]   pool [4];
      logic [TASK_ID_W-1:0] tid;
      logic [LEVEL_W-1:0]   prio;
      bprq_pkg::op_type     op;
      int unsigned          probe;
      foreach (pool[i]) pool[i] = LEVEL_W'($urandom);
      // keep one extreme level in every pool
      pool[0] = ($urandom_range(1, 0) == 1) ? '1 : '0;
      for (int n = 0; n < items; n++) begin
         if (idling && $urandom_range(99, 0) < 10) hold_off($urandom_range(6, 1));
         tid  = TASK_ID_W'($urandom);
         prio = ($urandom_range(1, 0) == 1) ? pool[$urandom_range(3, 0)] : LEVEL_W'($urandom);
         op   = ($urandom_range(99, 0) < enq_pct) ? bprq_pkg::OP_ENQUEUE : bprq_pkg::OP_DEQUEUE;
         // Until every link entry has been written, re-queuing a queued task
         // could splice a list onto a link that was never written. Advance to
         // a free task instead, and dequeue when every task is queued.
         if (op == bprq_pkg::OP_ENQUEUE && !board.links_complete()) begin
            probe = 0;
            while (probe < DEF_NUM_TASKS && board.is_queued(tid)) begin
               tid++;
               probe++;
            end
            if (probe == DEF_NUM_TASKS) op = bprq_pkg::OP_DEQUEUE;
         end
         transfer_request(op, tid, prio);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed opening: empty queue, both ends of the level range, group
      // boundaries, appending behind a queued task and FIFO order in a level
      transfer_request(bprq_pkg::OP_DEQUEUE, '1, '1);
      transfer_request(bprq_pkg::OP_ENQUEUE, '0, '0);
      transfer_request(bprq_pkg::OP_DEQUEUE, '0, '0);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd63, 8'd255);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd1,  8'd255);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd2,  8'd0);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd3,  8'd31);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd4,  8'd32);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd5,  8'd224);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd10, 8'd128);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd11, 8'd128);
      transfer_request(bprq_pkg::OP_ENQUEUE, 6'd12, 8'd128);
      // drain all nine and then hit the empty queue once more
      repeat (10) transfer_request(bprq_pkg::OP_DEQUEUE, TASK_ID_W'($urandom),
                                   LEVEL_W'($urandom));
      wait_drained();

      // random phases alternate between filling and draining; two of them
      // run without any idle cycles
      for (int p = 0; p < 8; p++) begin
         run_phase(100, (p % 2 == 0) ? 70 : 35, !(p == 2 || p == 5));
         wait_drained();
      end

      repeat (8) @(posedge clock);
      board.check_drained();
      $display("Transferred %0d commands: %0d enqueues (%0d onto an already queued task), %0d %s",
               sent, board.enqueues, board.repeats, board.dequeues, "dequeues");
      $display("Dequeues returned %0d tasks and found the queue empty %0d times",
               board.hits, board.misses);
      if (board.errors == 0) begin
         $display("bitmap_priority_ready_queue: match");
      end else begin
         $display("bitmap_priority_ready_queue: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake: the slowest run is about ten
   // microseconds, so allow ample margin.
   initial begin
      #200000;
      $display("Timeout waiting for the block");
      $display("bitmap_priority_ready_queue: mismatch");
      $finish;
   end

endmodule
